FILE: design/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the barometric pressure compensator.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int COEFF_W   = 16;
  localparam int RAW_W     = 24;

  localparam int DT_W      = 25;
  localparam int TEMP_W    = 20;
  localparam int WIDE_W    = 42;
  localparam int CORR_W    = 40;
  localparam int MUL_W     = 26;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 66;
  localparam int PDIFF_W   = 48;
  localparam int FSUM_W    = 36;

  localparam int TOUT_W    = 15;
  localparam int PRES_W    = 17;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  localparam int TEMP_REF   = 2000;
  localparam int TEMP_COLD  = -1500;
  localparam int TEMP_MIN   = -4000;
  localparam int TEMP_MAX   = 8500;
  localparam int PRES_MIN   = 1000;
  localparam int PRES_MAX   = 120000;
  localparam int ALPHA_ON   = 6553;
  localparam int FILT_ROUND = 32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS     = 3'd0,
    REG_OFF      = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5,
    REG_ALPHA    = 3'd6
  } bpc_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEMP,
    ST_OFF,
    ST_SENS,
    ST_T2,
    ST_A2,
    ST_B2,
    ST_CORR,
    ST_APPLY,
    ST_PLO,
    ST_PHI,
    ST_PSUM,
    ST_PRES,
    ST_CLAMP,
    ST_FILT,
    ST_FOUT
  } bpc_state_t;

endpackage

FILE: design/baro_pressure_compensator_unit.sv
// ----------------------------------------------------------------------------
// baro_pressure_compensator_unit
// Second-order compensated barometer: raw D1/D2 words plus six calibration
// words give temperature in 0.01 C and pressure in Pa, with optional smoothing.
// ----------------------------------------------------------------------------
// One input word is taken in idle and its result goes to the output register
// before the next word is taken, so the block processes one word at a time.
// The sequence runs on the one signed 26x26 multiplier, which is shared by
// all nine products (temperature, offset, sensitivity, the three squares,
// the two halves of the pressure product and the filter) under a sequencer.
// A finished result waits in the output register while the next word is
// processed; the last step stalls only if that register is still full.
// Configuration writes are taken in every cycle; indices past the list are
// dropped. The filter is used when alpha exceeds 6553 and is primed by the
// first filtered word.
module baro_pressure_compensator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // raw_pressure [23:0], raw_temperature [47:24]
  input  logic [bpc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // temperature_centi [14:0], pressure_pa [31:15], clipped [32], zero pad
  output logic [bpc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::COEFF_W-1:0]    cfg_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready
);
  import bpc_pkg::*;

  bpc_state_t state_r, state_nxt;

  logic [COEFF_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, alpha_r;

  logic [RAW_W-1:0]          d1_r;
  logic signed [DT_W-1:0]    dt_r;
  logic signed [TEMP_W-1:0]  temp_r;
  logic signed [WIDE_W-1:0]  off_r, sens_r;
  logic signed [CORR_W-1:0]  t2_r, off2_r, sens2_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [PDIFF_W-1:0] pdiff_r;
  logic [PRES_W-1:0]         pres_r, filt_r;
  logic signed [TOUT_W-1:0]  tout_r;
  logic                      clip_r, primed_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic                      in_acc, out_load, filt_on, cold, vcold;

  logic signed [TEMP_W-1:0]  temp_calc, a_val, b_val;
  logic signed [WIDE_W-1:0]  off_calc, sens_calc;
  logic signed [CORR_W-1:0]  sq, five_sq, seven_sq, eleven_sq;
  logic signed [PDIFF_W-1:0] p_sh;
  logic [PRES_W-1:0]         pres_calc, old_val;
  logic signed [TOUT_W-1:0]  tout_calc;
  logic                      clip_calc;
  logic signed [PRES_W:0]    fdiff;
  logic signed [FSUM_W-1:0]  fsum;
  logic [PRES_W-1:0]         fres;

  assign in_acc    = in_tvalid && in_tready;
  assign filt_on   = (alpha_r > COEFF_W'(ALPHA_ON));
  assign cold      = (temp_r < TEMP_W'(TEMP_REF));
  assign vcold     = (temp_r < TEMP_W'(TEMP_COLD));
  assign out_load  = (state_r == ST_FOUT) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // datapath arithmetic
  always_comb begin
    temp_calc = TEMP_W'(TEMP_REF) + TEMP_W'(prod_r >>> 23);
    off_calc  = WIDE_W'({c2_r, 16'b0}) + WIDE_W'(prod_r >>> 7);
    sens_calc = WIDE_W'({c1_r, 15'b0}) + WIDE_W'(prod_r >>> 8);
    a_val     = temp_r - TEMP_W'(TEMP_REF);
    b_val     = temp_r - TEMP_W'(TEMP_COLD);
    sq        = CORR_W'(prod_r);
    five_sq   = (sq <<< 2) + sq;
    seven_sq  = (sq <<< 3) - sq;
    eleven_sq = (sq <<< 3) + (sq <<< 1) + sq;

    p_sh      = pdiff_r >>> 15;
    clip_calc = 1'b0;
    if (p_sh < PDIFF_W'(PRES_MIN)) begin
      pres_calc = PRES_W'(PRES_MIN);
      clip_calc = 1'b1;
    end else if (p_sh > PDIFF_W'(PRES_MAX)) begin
      pres_calc = PRES_W'(PRES_MAX);
      clip_calc = 1'b1;
    end else begin
      pres_calc = p_sh[PRES_W-1:0];
    end
    if (temp_r < TEMP_W'(TEMP_MIN)) begin
      tout_calc = TOUT_W'(TEMP_MIN);
      clip_calc = 1'b1;
    end else if (temp_r > TEMP_W'(TEMP_MAX)) begin
      tout_calc = TOUT_W'(TEMP_MAX);
      clip_calc = 1'b1;
    end else begin
      tout_calc = temp_r[TOUT_W-1:0];
    end

    old_val = primed_r ? filt_r : pres_r;
    fdiff   = $signed({1'b0, old_val}) - $signed({1'b0, pres_r});
    fsum    = $signed(FSUM_W'({pres_r, 16'b0})) + FSUM_W'(prod_r)
              + FSUM_W'(FILT_ROUND);
    fres    = fsum[PRES_W+15:16];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_TEMP;
      ST_TEMP:  state_nxt = ST_OFF;
      ST_OFF:   state_nxt = ST_SENS;
      ST_SENS:  state_nxt = ST_T2;
      ST_T2:    state_nxt = ST_A2;
      ST_A2:    state_nxt = ST_B2;
      ST_B2:    state_nxt = ST_CORR;
      ST_CORR:  state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_PLO;
      ST_PLO:   state_nxt = ST_PHI;
      ST_PHI:   state_nxt = ST_PSUM;
      ST_PSUM:  state_nxt = ST_PRES;
      ST_PRES:  state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_FILT;
      ST_FILT:  state_nxt = ST_FOUT;
      ST_FOUT:  if (out_load) state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operands
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_TEMP: begin
        mul_a = MUL_W'(dt_r);
        mul_b = $signed(MUL_W'(c6_r));
      end
      ST_OFF: begin
        mul_a = MUL_W'(dt_r);
        mul_b = $signed(MUL_W'(c4_r));
      end
      ST_SENS: begin
        mul_a = MUL_W'(dt_r);
        mul_b = $signed(MUL_W'(c3_r));
      end
      ST_T2: begin
        mul_a = MUL_W'(dt_r);
        mul_b = MUL_W'(dt_r);
      end
      ST_A2: begin
        mul_a = MUL_W'(a_val);
        mul_b = MUL_W'(a_val);
      end
      ST_B2: begin
        mul_a = MUL_W'(b_val);
        mul_b = MUL_W'(b_val);
      end
      ST_PLO: begin
        mul_a = $signed(MUL_W'(d1_r));
        mul_b = $signed(MUL_W'(sens_r[19:0]));
      end
      ST_PHI: begin
        mul_a = $signed(MUL_W'(d1_r));
        mul_b = MUL_W'(sens_r >>> 20);
      end
      ST_FILT, ST_FOUT: begin
        mul_a = MUL_W'(fdiff);
        mul_b = $signed(MUL_W'(alpha_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        d1_r <= in_tdata[RAW_W-1:0];
        dt_r <= $signed({1'b0, in_tdata[2*RAW_W-1:RAW_W]})
                - $signed({1'b0, c5_r, 8'b0});
      end
      ST_OFF:  temp_r <= temp_calc;
      ST_SENS: off_r  <= off_calc;
      ST_T2:   sens_r <= sens_calc;
      ST_A2:   t2_r   <= cold ? CORR_W'(prod_r >>> 31) : '0;
      ST_B2: begin
        off2_r  <= cold ? (five_sq >>> 1) : '0;
        sens2_r <= cold ? (five_sq >>> 2) : '0;
      end
      ST_CORR: if (vcold) begin
        off2_r  <= off2_r + seven_sq;
        sens2_r <= sens2_r + (eleven_sq >>> 1);
      end
      ST_APPLY: begin
        temp_r <= temp_r - TEMP_W'(t2_r);
        off_r  <= off_r - WIDE_W'(off2_r);
        sens_r <= sens_r - WIDE_W'(sens2_r);
      end
      ST_PHI:   acc_r   <= ACC_W'(prod_r);
      ST_PSUM:  acc_r   <= acc_r + (ACC_W'(prod_r) <<< 20);
      ST_PRES:  pdiff_r <= PDIFF_W'(acc_r >>> 21) - PDIFF_W'(off_r);
      ST_CLAMP: begin
        pres_r <= pres_calc;
        tout_r <= tout_calc;
        clip_r <= clip_calc;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {(OUT_DATA_W-PRES_W-TOUT_W-1)'(0), clip_r,
                     filt_on ? fres : pres_r, tout_r};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      primed_r    <= 1'b0;
      filt_r      <= '0;
      c1_r        <= '0;
      c2_r        <= '0;
      c3_r        <= '0;
      c4_r        <= '0;
      c5_r        <= '0;
      c6_r        <= '0;
      alpha_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (out_load && filt_on) begin
        filt_r   <= fres;
        primed_r <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SENS:     c1_r    <= cfg_data;
          REG_OFF:      c2_r    <= cfg_data;
          REG_TCS:      c3_r    <= cfg_data;
          REG_TCO:      c4_r    <= cfg_data;
          REG_TREF:     c5_r    <= cfg_data;
          REG_TEMPSENS: c6_r    <= cfg_data;
          REG_ALPHA:    alpha_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_TEMP))
    else $error("accepted word did not start the sequence");

  a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("filter lost its primed state");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_data_r[TOUT_W-1:0]) >= TOUT_W'(TEMP_MIN)
                  && $signed(out_data_r[TOUT_W-1:0]) <= TOUT_W'(TEMP_MAX)))
    else $error("temperature out of range");

  a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[TOUT_W+PRES_W-1:TOUT_W] >= PRES_W'(PRES_MIN)
                  && out_data_r[TOUT_W+PRES_W-1:TOUT_W] <= PRES_W'(PRES_MAX)))
    else $error("pressure out of range");

endmodule

FILE: test/baro_pressure_compensator_unit_tb.sv
// ----------------------------------------------------------------------------
// baro_pressure_compensator_unit_tb
// Self-checking bench for the compensated barometer. A scoreboard object
// predicts temperature, pressure and the clip flag for each accepted word.
// The prediction covers the cold and very cold corrections and the smoothing
// filter. Results are compared in order. Directed words hit the temperature
// boundaries, the clamps and the filter priming. Random phases then reload
// the coefficients and send mostly plausible readings, with random gaps and
// output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module baro_pressure_compensator_unit_tb;
  import bpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RAW_MAX     = 16777215;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 20;
  localparam int PHASE_WORDS = 50;
  localparam int FACTORY [6] = '{40127, 36924, 23317, 23282, 33464, 28312};

  typedef struct {
    logic signed [TOUT_W-1:0] temp_centi;
    logic [PRES_W-1:0]        pressure_pa;
    logic                     clipped;
  } reading_t;

  class baro_scoreboard;
    logic [COEFF_W-1:0] coeff [NUM_REGS];
    logic [PRES_W-1:0]  smooth_pres;
    bit                 smooth_primed;
    reading_t           pending_readings [$];
    int errors, checked, n_writes, n_cool, n_frigid, n_clip, n_smooth;

    function new();
      foreach (coeff[i]) coeff[i] = '0;
      smooth_pres = '0;
      smooth_primed = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] val);
      n_writes++;
      if (idx < NUM_REGS) coeff[idx] = val;
    endfunction

    function reading_t compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
      longint rp, rt, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t2, off2, sens2, p, a, b;
      longint unsigned acc, alpha;
      reading_t r;
      rp = d1;
      rt = d2;
      c1 = coeff[REG_SENS];
      c2 = coeff[REG_OFF];
      c3 = coeff[REG_TCS];
      c4 = coeff[REG_TCO];
      c5 = coeff[REG_TREF];
      c6 = coeff[REG_TEMPSENS];
      alpha = coeff[REG_ALPHA];
      r.clipped = 1'b0;
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      dt = rt - c5 * 256;
      temp = TEMP_REF + ((dt * c6) >>> 23);
      off = c2 * 65536 + ((c4 * dt) >>> 7);
      sens = c1 * 32768 + ((c3 * dt) >>> 8);
      if (temp < TEMP_REF) begin
        n_cool++;
        a = temp - TEMP_REF;
        t2 = (dt * dt) >>> 31;
        off2 = (5 * a * a) >>> 1;
        sens2 = off2 >>> 1;
      end
      // coldest range stacks on top of the below-20 C terms
      if (temp < TEMP_COLD) begin
        n_frigid++;
        b = temp - TEMP_COLD;
        off2 += 7 * b * b;
        sens2 += (11 * b * b) >>> 1;
      end
      temp -= t2;
      off -= off2;
      sens -= sens2;
      p = (((rp * sens) >>> 21) - off) >>> 15;
      if (temp < TEMP_MIN) begin temp = TEMP_MIN; r.clipped = 1'b1; end
      if (temp > TEMP_MAX) begin temp = TEMP_MAX; r.clipped = 1'b1; end
      if (p < PRES_MIN) begin p = PRES_MIN; r.clipped = 1'b1; end
      if (p > PRES_MAX) begin p = PRES_MAX; r.clipped = 1'b1; end
      if (r.clipped) n_clip++;
      r.temp_centi = temp[TOUT_W-1:0];
      r.pressure_pa = p[PRES_W-1:0];
      if (alpha > ALPHA_ON) begin
        n_smooth++;
        if (!smooth_primed) begin
          smooth_pres = p[PRES_W-1:0];
          smooth_primed = 1;
        end
        acc = longint'(p) * (65536 - alpha) + longint'(smooth_pres) * alpha + FILT_ROUND;
        smooth_pres = acc[PRES_W+15:16];
        r.pressure_pa = smooth_pres;
      end
      return r;
    endfunction

    function void note_input(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
      pending_readings.push_back(compensate(d1, d2));
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      reading_t want, got;
      got.temp_centi = word[TOUT_W-1:0];
      got.pressure_pa = word[TOUT_W+PRES_W-1:TOUT_W];
      got.clipped = word[TOUT_W+PRES_W];
      checked++;
      if (pending_readings.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: T=%0d P=%0d clip=%0b",
                   got.temp_centi, got.pressure_pa, got.clipped);
        return;
      end
      want = pending_readings.pop_front();
      if (want.temp_centi !== got.temp_centi || want.pressure_pa !== got.pressure_pa ||
          want.clipped !== got.clipped) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at word %0d: expected T=%0d P=%0d clip=%0b, got T=%0d P=%0d clip=%0b",
                   checked, want.temp_centi, want.pressure_pa, want.clipped,
                   got.temp_centi, got.pressure_pa, got.clipped);
      end
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COEFF_W-1:0]    cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  baro_scoreboard sb = new();
  bit tx_burst;
  bit rx_burst;
  int unsigned cycle_cnt;
  int sent;

  baro_pressure_compensator_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stall before each word
  initial begin : drain
    int rx_wait;
    rx_wait = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_wait > 0) begin
        out_tready = 1'b0;
        rx_wait--;
      end else begin
        out_tready = 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        rx_wait = rx_burst ? 0 : $urandom_range(0, 12);
      end
    end
  end

  task automatic send_reading(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tdata = {d2, d1};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(d1, d2);
    sent++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic random_settings();
    int mode, pick;
    logic [COEFF_W-1:0] v;
    mode = $urandom_range(0, 9);
    for (int i = REG_SENS; i <= REG_TEMPSENS; i++) begin
      if (mode <= 5) v = 16'(FACTORY[i] + int'($urandom_range(0, 8191)) - 4096);
      else if (mode == 8) v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else v = 16'($urandom);
      if (mode != 9 || $urandom_range(0, 1)) cfg_write(i[CFG_IDX_W-1:0], v);
    end
    pick = $urandom_range(0, 5);
    case (pick)
      0: v = 16'd0;
      1: v = 16'(ALPHA_ON);
      2: v = 16'(ALPHA_ON + 1);
      3: v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    cfg_write(REG_ALPHA, v);
    if ($urandom_range(0, 2) == 0) cfg_write(REG_UNUSED, 16'($urandom));
  endtask

  task automatic send_random_reading();
    int tr;
    logic [RAW_W-1:0] d1, d2;
    if ($urandom_range(0, 9) < 8) begin
      tr = int'(sb.coeff[REG_TREF]) * 256 + int'($urandom_range(0, 6000000)) - 3000000;
      if (tr < 0) tr = 0;
      if (tr > RAW_MAX) tr = RAW_MAX;
      d2 = tr[RAW_W-1:0];
      if ($urandom_range(0, 9) < 7) d1 = 24'($urandom_range(3500000, 11000000));
      else d1 = 24'($urandom);
    end else begin
      d1 = 24'($urandom);
      d2 = 24'($urandom);
    end
    send_reading(d1, d2);
  endtask

  initial begin : main
    rst_n = 1'b0;
    in_tdata = '0;
    in_tvalid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_valid = 1'b0;
    tx_burst = 0;
    rx_burst = 0;
    sent = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // unprogrammed coefficients
    send_reading(24'h000000, 24'h000000);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h000000, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'h000000);
    wait_drained();

    for (int i = REG_SENS; i <= REG_TEMPSENS; i++)
      cfg_write(i[CFG_IDX_W-1:0], 16'(FACTORY[i]));
    cfg_write(REG_ALPHA, 16'd0);
    cfg_write(REG_UNUSED, 16'hFFFF);
    send_reading(24'd9085466, 24'd8569150);   // warm
    send_reading(24'd9085466, 24'd8566784);   // exactly 20.00 C
    send_reading(24'd9085466, 24'd8566783);   // just below 20.00 C
    send_reading(24'd9085466, 24'd8270484);   // about 10 C
    send_reading(24'd9085466, 24'd7529764);   // exactly -15.00 C
    send_reading(24'd9085466, 24'd7529763);   // just below -15.00 C
    send_reading(24'd9085466, 24'd7085284);   // about -30 C
    send_reading(24'd9085466, 24'd5000000);   // temperature low clamp
    send_reading(24'd9085466, 24'hFFFFFF);    // temperature high clamp
    send_reading(24'h000000, 24'd8569150);    // pressure low clamp
    send_reading(24'hFFFFFF, 24'd8569150);    // pressure high clamp
    wait_drained();

    // filter: off at the threshold, primed just above, paused, resumed
    cfg_write(REG_ALPHA, 16'(ALPHA_ON));
    send_reading(24'd9085466, 24'd8569150);
    wait_drained();
    cfg_write(REG_ALPHA, 16'(ALPHA_ON + 1));
    send_reading(24'd9085466, 24'd8569150);
    send_reading(24'd8500000, 24'd8569150);
    send_reading(24'd9600000, 24'd8569150);
    wait_drained();
    cfg_write(REG_ALPHA, 16'd0);
    send_reading(24'd8000000, 24'd8569150);
    wait_drained();
    cfg_write(REG_ALPHA, 16'hFFFF);
    send_reading(24'd10000000, 24'd8569150);
    send_reading(24'd4000000, 24'd8569150);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      random_settings();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      repeat (PHASE_WORDS) send_random_reading();
    end

    wait_drained();
    rx_burst = 0;
    repeat (40) @(posedge clk);

    $display("Sent %0d readings over %0d register writes and %0d random phases.",
             sent, sb.n_writes, PHASES);
    $display("Below 20 C: %0d, below -15 C: %0d, saturated: %0d, smoothed: %0d, errors: %0d.",
             sb.n_cool, sb.n_frigid, sb.n_clip, sb.n_smooth, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
